// ===== sv/tic_pkg.sv =====
// ----------------------------------------------------------------------------
// tic_pkg - Thumb instruction classifier package
// Form codes, group codes and the result record shared by the decoder and the
// top level.
// ----------------------------------------------------------------------------
package tic_pkg;

  localparam int unsigned HalfwordWidth = 16;
  localparam int unsigned FormWidth     = 7;

  // Major group, instruction bits 15..13
  typedef enum logic [2:0] {
    GRP_SHIFT_ADDSUB = 3'd0,
    GRP_IMMEDIATE    = 3'd1,
    GRP_ALU_LDST_REG = 3'd2,
    GRP_LDST_WORD_B  = 3'd3,
    GRP_LDST_HALF_SP = 3'd4,
    GRP_MISC         = 3'd5,
    GRP_MULTI_COND   = 3'd6,
    GRP_BRANCH       = 3'd7
  } group_t;

  typedef enum logic [FormWidth-1:0] {
    FORM_UNDEFINED      = 7'd0,
    FORM_LSL1           = 7'd1,
    FORM_LSR1           = 7'd2,
    FORM_ASR1           = 7'd3,
    FORM_ADD1           = 7'd4,
    FORM_ADD3           = 7'd5,
    FORM_SUB1           = 7'd6,
    FORM_SUB3           = 7'd7,
    FORM_MOV2           = 7'd8,
    FORM_ADD2           = 7'd9,
    FORM_CMP1           = 7'd10,
    FORM_MOV1           = 7'd11,
    FORM_SUB2           = 7'd12,
    FORM_LDR3           = 7'd13,
    FORM_STR2           = 7'd14,
    FORM_STRH2          = 7'd15,
    FORM_STRB2          = 7'd16,
    FORM_LDRSB          = 7'd17,
    FORM_LDR2           = 7'd18,
    FORM_LDRH2          = 7'd19,
    FORM_LDRB2          = 7'd20,
    FORM_LDRSH          = 7'd21,
    FORM_ADC            = 7'd22,
    FORM_ADD4           = 7'd23,
    FORM_AND            = 7'd24,
    FORM_ASR2           = 7'd25,
    FORM_BIC            = 7'd26,
    FORM_BLX2           = 7'd27,
    FORM_BX             = 7'd28,
    FORM_CMN            = 7'd29,
    FORM_CMP2           = 7'd30,
    FORM_CMP3           = 7'd31,
    FORM_EOR            = 7'd32,
    FORM_LSL2           = 7'd33,
    FORM_LSR2           = 7'd34,
    FORM_MOV3           = 7'd35,
    FORM_MUL            = 7'd36,
    FORM_MVN            = 7'd37,
    FORM_NEG            = 7'd38,
    FORM_ORR            = 7'd39,
    FORM_ROR            = 7'd40,
    FORM_SBC            = 7'd41,
    FORM_TST            = 7'd42,
    FORM_STR1           = 7'd43,
    FORM_LDR1           = 7'd44,
    FORM_STRB1          = 7'd45,
    FORM_LDRB1          = 7'd46,
    FORM_STRH1          = 7'd47,
    FORM_LDRH1          = 7'd48,
    FORM_STR3           = 7'd49,
    FORM_LDR4           = 7'd50,
    FORM_ADD5           = 7'd51,
    FORM_ADD6           = 7'd52,
    FORM_ADD7           = 7'd53,
    FORM_SUB4           = 7'd54,
    FORM_PUSH           = 7'd55,
    FORM_BKPT           = 7'd56,
    FORM_POP            = 7'd57,
    FORM_STMIA          = 7'd58,
    FORM_LDMIA          = 7'd59,
    FORM_SWI            = 7'd60,
    FORM_B1             = 7'd61,
    FORM_B2             = 7'd62,
    FORM_BLX1           = 7'd63,
    FORM_BL_BLX1_PREFIX = 7'd64,
    FORM_BL             = 7'd65
  } form_t;

  // Result record, packed as it leaves on the stream: form low, flag above
  typedef struct packed {
    logic  is_undefined;
    form_t instruction_form;
  } result_t;

endpackage

// ===== sv/tic_decoder.sv =====
// ----------------------------------------------------------------------------
// tic_decoder - Thumb halfword form decoder
// Pure combinational classification of one halfword into its form code.
// ----------------------------------------------------------------------------
module tic_decoder
  import tic_pkg::*;
(
  input  logic [HalfwordWidth-1:0] halfword,
  output result_t                  result
);

  form_t  form;
  group_t grp;
  logic [1:0] op;

  assign grp = group_t'(halfword[15:13]);
  assign op  = halfword[12:11];

  always_comb begin
    form = FORM_UNDEFINED;
    case (grp)
      GRP_SHIFT_ADDSUB: begin
        case (op)
          2'd0:    form = FORM_LSL1;
          2'd1:    form = FORM_LSR1;
          2'd2:    form = FORM_ASR1;
          default: begin
            // MOV2 encoding falls under ADD1 here
            case (halfword[10:9])
              2'b10:   form = FORM_ADD1;
              2'b00:   form = FORM_ADD3;
              2'b11:   form = FORM_SUB1;
              default: form = FORM_SUB3;
            endcase
          end
        endcase
      end
      GRP_IMMEDIATE: begin
        case (op)
          2'd0:    form = FORM_MOV1;
          2'd1:    form = FORM_CMP1;
          2'd2:    form = FORM_ADD2;
          default: form = FORM_SUB2;
        endcase
      end
      GRP_ALU_LDST_REG: begin
        if (op == 2'd1) begin
          form = FORM_LDR3;
        end else if (halfword[12]) begin
          case (halfword[11:9])
            3'd0:    form = FORM_STR2;
            3'd1:    form = FORM_STRH2;
            3'd2:    form = FORM_STRB2;
            3'd3:    form = FORM_LDRSB;
            3'd4:    form = FORM_LDR2;
            3'd5:    form = FORM_LDRH2;
            3'd6:    form = FORM_LDRB2;
            default: form = FORM_LDRSH;
          endcase
        end else if (!halfword[10]) begin
          case (halfword[9:6])
            4'd0:    form = FORM_AND;
            4'd1:    form = FORM_EOR;
            4'd2:    form = FORM_LSL2;
            4'd3:    form = FORM_LSR2;
            4'd4:    form = FORM_ASR2;
            4'd5:    form = FORM_ADC;
            4'd6:    form = FORM_SBC;
            4'd7:    form = FORM_ROR;
            4'd8:    form = FORM_TST;
            4'd9:    form = FORM_NEG;
            4'd10:   form = FORM_CMP2;
            4'd11:   form = FORM_CMN;
            4'd12:   form = FORM_ORR;
            4'd13:   form = FORM_MUL;
            4'd14:   form = FORM_BIC;
            default: form = FORM_MVN;
          endcase
        end else begin
          case (halfword[9:8])
            2'd0:    form = FORM_ADD4;
            2'd1:    form = FORM_CMP3;
            2'd2:    form = FORM_MOV3;
            default: form = halfword[7] ? FORM_BLX2 : FORM_BX;
          endcase
        end
      end
      GRP_LDST_WORD_B: begin
        case (op)
          2'd0:    form = FORM_STR1;
          2'd1:    form = FORM_LDR1;
          2'd2:    form = FORM_STRB1;
          default: form = FORM_LDRB1;
        endcase
      end
      GRP_LDST_HALF_SP: begin
        case (op)
          2'd0:    form = FORM_STRH1;
          2'd1:    form = FORM_LDRH1;
          2'd2:    form = FORM_STR3;
          default: form = FORM_LDR4;
        endcase
      end
      GRP_MISC: begin
        case (op)
          2'd0: form = FORM_ADD5;
          2'd1: form = FORM_ADD6;
          2'd2: begin
            if (halfword[10:7] == 4'd0)       form = FORM_ADD7;
            else if (halfword[10:7] == 4'd1)  form = FORM_SUB4;
            else if (halfword[10:9] == 2'b10) form = FORM_PUSH;
            else                              form = FORM_UNDEFINED;
          end
          default: begin
            case (halfword[10:8])
              3'd6:       form = FORM_BKPT;
              3'd4, 3'd5: form = FORM_POP;
              default:    form = FORM_UNDEFINED;
            endcase
          end
        endcase
      end
      GRP_MULTI_COND: begin
        if (op == 2'd0)                    form = FORM_STMIA;
        else if (op == 2'd1)               form = FORM_LDMIA;
        else if (halfword[12:8] == 5'h1F)  form = FORM_SWI;
        else if (halfword[12:8] == 5'h1E)  form = FORM_UNDEFINED; // cond AL: undef space
        else                               form = FORM_B1;
      end
      default: begin
        case (op)
          2'd0:    form = FORM_B2;
          2'd1:    form = FORM_BLX1;
          2'd2:    form = FORM_BL_BLX1_PREFIX;
          default: form = FORM_BL;
        endcase
      end
    endcase
  end

  assign result.instruction_form = form;
  assign result.is_undefined     = (form == FORM_UNDEFINED);

endmodule

// ===== sv/thumb_instruction_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// thumb_instruction_classifier_unit - Thumb instruction form classifier
// Streams 16-bit Thumb halfwords in and one form code per halfword out.
// ----------------------------------------------------------------------------
// Takes one Thumb halfword per item on the slave stream and returns one item
// per halfword on the master stream, in order, carrying the instruction form
// code (0 = undefined, 1..65 = named forms) and an undefined flag. The unit
// sustains one item per clock while the output is not stalled: the halfword
// lands in an input register, the decoder sits between that register and the
// result register, and tvalid rises once the result register loads the
// decoded item. Both registers hand off in the same cycle, so a result
// stalled at the output still lets one more halfword be taken into the input
// register. No state persists between items; reset only empties the two
// stages.
module thumb_instruction_classifier_unit
  import tic_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Slave stream. tdata: [15:0] instruction_halfword
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  // Master stream. tdata: [6:0] instruction_form, [7] is_undefined
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata
);

  // Input stage
  logic                     in_valid;
  logic [HalfwordWidth-1:0] in_data;
  // Result stage
  logic                     out_valid;
  result_t                  out_data;

  result_t dec_res;
  logic    out_ready;   // result stage can take a new item this cycle
  logic    in_ready;    // input stage can take a new item this cycle

  assign out_ready = !out_valid || m_axis_tready;
  assign in_ready  = !in_valid || out_ready;

  tic_decoder u_dec (
    .halfword (in_data),
    .result   (dec_res)
  );

  // Input register: refills whenever its item moves on or it is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && s_axis_tvalid) begin
      in_data <= s_axis_tdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && in_valid) begin
      out_data <= dec_res;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_flag_matches_form : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.is_undefined == (out_data.instruction_form == FORM_UNDEFINED)))
    else $error("undefined flag disagrees with form code");

  a_mov2_shadowed : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.instruction_form != FORM_MOV2))
    else $error("MOV2 reported although shadowed by ADD1");

  a_form_in_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.instruction_form <= FORM_BL))
    else $error("form code out of range");

  a_stage_handoff : assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_ready) |=> (out_valid && (out_data == $past(dec_res))))
    else $error("decoded item lost between stages");

  a_accept_fills_input : assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (in_valid && (in_data == $past(s_axis_tdata))))
    else $error("accepted halfword not captured");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for thumb_instruction_classifier_unit
// Feeds a short table of hand-picked halfwords, then biased random ones, and
// checks every form code and undefined flag against typed rows or thumb_form.
// ----------------------------------------------------------------------------
module tb;
  import tic_pkg::*;

  typedef struct {
    logic [15:0] halfword;
    bit          typed;     // form below is the expected one
    form_t       form;
  } probe_t;

  localparam int unsigned NumProbes = 26;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  form_t       pending_forms[$];
  int unsigned error_count = 0;
  bit          calm = 1'b0;  // no idling on either side once set

  // Rows with a typed form: extremes, the shadowed MOV2 pattern, the gaps in
  // the misc space and the undefined condition. The rest go to the decoder.
  probe_t probes [NumProbes] = '{
    '{16'h0000, 1'b1, FORM_LSL1},
    '{16'hFFFF, 1'b1, FORM_BL},
    '{16'h1C00, 1'b1, FORM_ADD1},
    '{16'hB200, 1'b1, FORM_UNDEFINED},
    '{16'hB6FF, 1'b1, FORM_UNDEFINED},
    '{16'hB800, 1'b1, FORM_UNDEFINED},
    '{16'hDE00, 1'b1, FORM_UNDEFINED},
    '{16'hDF00, 1'b0, FORM_UNDEFINED},
    '{16'h4000, 1'b0, FORM_UNDEFINED},
    '{16'h43C0, 1'b0, FORM_UNDEFINED},
    '{16'h4700, 1'b0, FORM_UNDEFINED},
    '{16'h4780, 1'b0, FORM_UNDEFINED},
    '{16'h4600, 1'b0, FORM_UNDEFINED},
    '{16'h4800, 1'b0, FORM_UNDEFINED},
    '{16'h5000, 1'b0, FORM_UNDEFINED},
    '{16'h5E00, 1'b0, FORM_UNDEFINED},
    '{16'h2000, 1'b0, FORM_UNDEFINED},
    '{16'h3800, 1'b0, FORM_UNDEFINED},
    '{16'h1800, 1'b0, FORM_UNDEFINED},
    '{16'hA800, 1'b0, FORM_UNDEFINED},
    '{16'hC000, 1'b0, FORM_UNDEFINED},
    '{16'hE000, 1'b0, FORM_UNDEFINED},
    '{16'hF000, 1'b0, FORM_UNDEFINED},
    '{16'hB080, 1'b0, FORM_UNDEFINED},
    '{16'hBC00, 1'b0, FORM_UNDEFINED},
    '{16'h8000, 1'b0, FORM_UNDEFINED}
  };

  thumb_instruction_classifier_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] instruction_halfword
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [6:0] instruction_form, [7] is_undefined
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioural decoder: checks run in the same order as the hardware, so the
  // MOV2 encoding falls into ADD1 first.
  function automatic form_t thumb_form(input logic [15:0] hw);
    logic [1:0] op;
    op = hw[12:11];
    case (group_t'(hw[15:13]))
      GRP_SHIFT_ADDSUB: begin
        if (op != 2'd3) return form_t'(FORM_LSL1 + op);
        case (hw[10:9])
          2'd2:    return FORM_ADD1;
          2'd0:    return FORM_ADD3;
          2'd3:    return FORM_SUB1;
          default: return FORM_SUB3;
        endcase
      end
      GRP_IMMEDIATE: begin
        case (op)
          2'd0:    return FORM_MOV1;
          2'd1:    return FORM_CMP1;
          2'd2:    return FORM_ADD2;
          default: return FORM_SUB2;
        endcase
      end
      GRP_ALU_LDST_REG: begin
        if (op == 2'd1) return FORM_LDR3;
        if (hw[12]) return form_t'(FORM_STR2 + hw[11:9]);
        if (!hw[10]) begin
          case (hw[9:6])
            4'd0:    return FORM_AND;
            4'd1:    return FORM_EOR;
            4'd2:    return FORM_LSL2;
            4'd3:    return FORM_LSR2;
            4'd4:    return FORM_ASR2;
            4'd5:    return FORM_ADC;
            4'd6:    return FORM_SBC;
            4'd7:    return FORM_ROR;
            4'd8:    return FORM_TST;
            4'd9:    return FORM_NEG;
            4'd10:   return FORM_CMP2;
            4'd11:   return FORM_CMN;
            4'd12:   return FORM_ORR;
            4'd13:   return FORM_MUL;
            4'd14:   return FORM_BIC;
            default: return FORM_MVN;
          endcase
        end
        case (hw[9:8])
          2'd0:    return FORM_ADD4;
          2'd1:    return FORM_CMP3;
          2'd2:    return FORM_MOV3;
          default: return hw[7] ? FORM_BLX2 : FORM_BX;
        endcase
      end
      GRP_LDST_WORD_B:  return form_t'(FORM_STR1 + op);
      GRP_LDST_HALF_SP: return form_t'(FORM_STRH1 + op);
      GRP_MISC: begin
        case (op)
          2'd0: return FORM_ADD5;
          2'd1: return FORM_ADD6;
          2'd2: begin
            if (hw[10:7] == 4'd0) return FORM_ADD7;
            if (hw[10:7] == 4'd1) return FORM_SUB4;
            if (hw[10:9] == 2'd2) return FORM_PUSH;
            return FORM_UNDEFINED;
          end
          default: begin
            if (hw[10:8] == 3'd6) return FORM_BKPT;
            if (hw[10:9] == 2'd2) return FORM_POP;
            return FORM_UNDEFINED;
          end
        endcase
      end
      GRP_MULTI_COND: begin
        if (op == 2'd0) return FORM_STMIA;
        if (op == 2'd1) return FORM_LDMIA;
        if (hw[12:8] == 5'h1F) return FORM_SWI;
        if (hw[12:8] == 5'h1E) return FORM_UNDEFINED;
        return FORM_B1;
      end
      default: return form_t'(FORM_B2 + op);
    endcase
  endfunction

  // Presents one halfword, maybe after an idle burst, and books its form once
  // the handshake is certain (both high at the falling edge before the rise).
  task automatic offer_halfword(input logic [15:0] hw, input form_t want);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= hw;
    do @(negedge clk); while (!s_axis_tready);
    pending_forms.push_back(want);
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] hw;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probes[i])
      offer_halfword(probes[i].halfword,
                     probes[i].typed ? probes[i].form : thumb_form(probes[i].halfword));

    // Drain the pipe completely once before the random part
    s_axis_tvalid <= 1'b0;
    while (pending_forms.size() != 0) @(posedge clk);
    @(posedge clk);

    // Random halfwords, biased towards the crowded corners of the encoding
    // space: ALU ops, hi-register ops, misc space and the condition field.
    for (int n = 0; n < 800; n++) begin
      calm = (n >= 700);
      hw = 16'($urandom);
      case ($urandom_range(0, 9))
        0:       hw[15:10] = 6'b010000;
        1:       hw[15:10] = 6'b010001;
        2:       hw[15:12] = 4'b1011;
        3:       hw[15:11] = 5'b11011;
        default: ;
      endcase
      offer_halfword(hw, thumb_form(hw));
    end

    s_axis_tvalid <= 1'b0;
    while (pending_forms.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Result side back-pressure: random stall bursts until the calm tail
  initial begin : result_stalls
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Result check: an item is taken at the next rise when both are high now
  always @(negedge clk) begin : check_results
    result_t got;
    form_t   want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (pending_forms.size() == 0) begin
        $error("unexpected result item: instruction_form %0d", got.instruction_form);
        error_count++;
      end else begin
        want = pending_forms.pop_front();
        if (got.instruction_form !== want) begin
          $error("instruction_form: expected %0d, got %0d", want, got.instruction_form);
          error_count++;
        end
        if (got.is_undefined !== (want == FORM_UNDEFINED)) begin
          $error("is_undefined: expected %0d, got %0d",
                 want == FORM_UNDEFINED, got.is_undefined);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
